### hdl/tcc_pkg.sv
// shared types and constants for the text console cursor engine
// holds the item structs, command records, config bundle and code names
// no dependencies
package tcc_pkg;

  // geometry limits
  localparam logic [7:0] MAX_COLUMNS = 8'd255;
  localparam logic [6:0] MAX_ROWS    = 7'd127;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register byte address width and register indexes
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_COLUMNS   = 3'd0;
  localparam logic [2:0] REG_ROWS      = 3'd1;
  localparam logic [2:0] REG_TAB_SHIFT = 3'd2;
  localparam logic [2:0] REG_FORE      = 3'd3;
  localparam logic [2:0] REG_BACK      = 3'd4;
  localparam logic [2:0] REG_OUT_EN    = 3'd5;

  // reset values of the registers
  localparam logic [7:0]  RST_COLUMNS   = 8'd80;
  localparam logic [6:0]  RST_ROWS      = 7'd25;
  localparam logic [2:0]  RST_TAB_SHIFT = 3'd2;
  localparam logic [31:0] RST_FORE      = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_BACK      = 32'h0000_0000;
  localparam logic        RST_OUT_EN    = 1'b1;

  // input action codes
  localparam logic ACT_PUT   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // result kinds
  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [6:0]  glyph;
    logic [31:0] fg_out;
    logic [31:0] bg_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  columns;
    logic [6:0]  rows;
    logic [2:0]  tab_shift;
    logic [31:0] fore_color;
    logic [31:0] back_color;
    logic        output_enable;
  } cfg_t;

  // what one item asks of the back end
  typedef enum logic [1:0] {
    CMD_DRAW,
    CMD_SCROLL,
    CMD_CLEAR,
    CMD_DRAW_SCROLL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] col;
    logic [6:0] row;
    logic [6:0] glyph;
  } cmd_t;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

endpackage

### hdl/tcc_front.sv
// front end: accepts items, keeps the cursor and classifies each item into at most one command
// depends on tcc_pkg
module tcc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  tcc_pkg::cfg_t   cfg,
  input  logic            in_push,
  input  tcc_pkg::in_item_t in_data,
  input  logic            q_full,
  output logic            q_wr,
  output tcc_pkg::cmd_t   q_wdata
);

  logic [7:0] cursor_col_r, cursor_col_nxt;
  logic [6:0] cursor_row_r, cursor_row_nxt;

  logic       accept;
  logic [7:0] cols_eff;
  logic [6:0] rows_eff;
  logic [7:0] row_inc;
  logic       nl_scroll;
  logic [6:0] nl_row;
  logic [8:0] tab_w;
  logic [8:0] tab_sum;
  logic [8:0] tab_col;
  logic [8:0] adv_col;
  logic       emit;
  tcc_pkg::cmd_t cmd;

  assign accept = in_push && !q_full;

  always_comb begin
    if (cfg.columns == 8'd0) begin
      cols_eff = 8'd1;
    end else if (cfg.columns > tcc_pkg::MAX_COLUMNS) begin
      cols_eff = tcc_pkg::MAX_COLUMNS;
    end else begin
      cols_eff = cfg.columns;
    end
    if (cfg.rows == 7'd0) begin
      rows_eff = 7'd1;
    end else if (cfg.rows > tcc_pkg::MAX_ROWS) begin
      rows_eff = tcc_pkg::MAX_ROWS;
    end else begin
      rows_eff = cfg.rows;
    end
  end

  // newline outcome, shared by lf, tab and wrap
  assign row_inc   = {1'b0, cursor_row_r} + 8'd1;
  assign nl_scroll = row_inc >= {1'b0, rows_eff};
  assign nl_row    = nl_scroll ? (rows_eff - 7'd1) : row_inc[6:0];

  // next tab stop: add the stop width and clear the low bits
  assign tab_w   = 9'd1 << cfg.tab_shift;
  assign tab_sum = {1'b0, cursor_col_r} + tab_w;
  assign tab_col = tab_sum & ~(tab_w - 9'd1);
  assign adv_col = {1'b0, cursor_col_r} + 9'd1;

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    emit           = 1'b0;
    cmd.op         = tcc_pkg::CMD_DRAW;
    cmd.col        = cursor_col_r;
    cmd.row        = cursor_row_r;
    cmd.glyph      = in_data.char_code[6:0];
    if (accept && cfg.output_enable) begin
      priority if (in_data.action == tcc_pkg::ACT_CLEAR) begin
        cmd.op         = tcc_pkg::CMD_CLEAR;
        emit           = 1'b1;
        cursor_col_nxt = 8'd0;
        cursor_row_nxt = 7'd0;
      end else if (in_data.char_code == tcc_pkg::CH_LF) begin
        cmd.op         = tcc_pkg::CMD_SCROLL;
        emit           = nl_scroll;
        cursor_col_nxt = 8'd0;
        cursor_row_nxt = nl_row;
      end else if (in_data.char_code == tcc_pkg::CH_CR) begin
        cursor_col_nxt = 8'd0;
      end else if (in_data.char_code == tcc_pkg::CH_TAB) begin
        if (tab_col >= {1'b0, cols_eff}) begin
          cmd.op         = tcc_pkg::CMD_SCROLL;
          emit           = nl_scroll;
          cursor_col_nxt = 8'd0;
          cursor_row_nxt = nl_row;
        end else begin
          cursor_col_nxt = tab_col[7:0];
        end
      end else if (in_data.char_code == tcc_pkg::CH_BS) begin
        if (cursor_col_r != 8'd0) begin
          cursor_col_nxt = cursor_col_r - 8'd1;
          cmd.col        = cursor_col_r - 8'd1;
          cmd.glyph      = tcc_pkg::CH_SPACE[6:0];
          emit           = 1'b1;
        end
      end else if (in_data.char_code[7] == 1'b0 && in_data.char_code >= tcc_pkg::CH_SPACE) begin
        emit = 1'b1;
        if (adv_col >= {1'b0, cols_eff}) begin
          cmd.op         = nl_scroll ? tcc_pkg::CMD_DRAW_SCROLL : tcc_pkg::CMD_DRAW;
          cursor_col_nxt = 8'd0;
          cursor_row_nxt = nl_row;
        end else begin
          cursor_col_nxt = adv_col[7:0];
        end
      end
      // other control codes and high bytes fall through with no command
    end
  end

  assign q_wr    = emit;
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= 8'd0;
      cursor_row_r <= 7'd0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

endmodule

### hdl/tcc_queue.sv
// short command queue between front and back end
// depends on tcc_pkg
module tcc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  tcc_pkg::cmd_t wdata,
  input  logic          rd,
  output tcc_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  tcc_pkg::cmd_t               mem_r [tcc_pkg::QDEPTH];
  logic [tcc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tcc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tcc_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign full  = count_r == tcc_pkg::QCNT_W'(tcc_pkg::QDEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == tcc_pkg::QPTR_W'(tcc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == tcc_pkg::QPTR_W'(tcc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) wr |-> !full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) rd |-> !empty)
    else $error("command queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tcc_pkg::QCNT_W'(tcc_pkg::QDEPTH))
    else $error("command queue count out of range");

endmodule

### hdl/tcc_back.sv
// back end: expands queued commands into result items and holds the output register
// depends on tcc_pkg
module tcc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tcc_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  tcc_pkg::cmd_t      q_head,
  output logic               q_rd,
  input  logic               out_pop,
  output logic               out_empty,
  output tcc_pkg::out_item_t out_data
);

  tcc_pkg::phase_t    phase_r, phase_nxt;
  logic               out_valid_r;
  tcc_pkg::out_item_t out_data_r;
  tcc_pkg::out_item_t res;
  logic               load;
  logic               fire;

  assign load = !out_valid_r || out_pop;
  assign fire = load && !q_empty;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        tcc_pkg::PH_FIRST: begin
          if (q_head.op == tcc_pkg::CMD_DRAW_SCROLL) phase_nxt = tcc_pkg::PH_SECOND;
        end
        tcc_pkg::PH_SECOND: begin
          phase_nxt = tcc_pkg::PH_FIRST;
        end
      endcase
    end
  end

  always_comb begin
    res.kind     = tcc_pkg::KIND_DRAW;
    res.cell_col = q_head.col;
    res.cell_row = q_head.row;
    res.glyph    = q_head.glyph;
    res.fg_out   = cfg.fore_color;
    res.bg_out   = cfg.back_color;
    res.last     = 1'b1;
    q_rd         = fire;
    unique case (q_head.op)
      tcc_pkg::CMD_DRAW: begin
      end
      tcc_pkg::CMD_SCROLL, tcc_pkg::CMD_CLEAR: begin
        res.kind     = (q_head.op == tcc_pkg::CMD_CLEAR) ? tcc_pkg::KIND_CLEAR
                                                         : tcc_pkg::KIND_SCROLL;
        res.cell_col = 8'd0;
        res.cell_row = 7'd0;
        res.glyph    = 7'd0;
        res.fg_out   = 32'd0;
      end
      tcc_pkg::CMD_DRAW_SCROLL: begin
        if (phase_r == tcc_pkg::PH_FIRST) begin
          // draw goes out first, the record stays for the scroll
          res.last = 1'b0;
          q_rd     = 1'b0;
        end else begin
          res.kind     = tcc_pkg::KIND_SCROLL;
          res.cell_col = 8'd0;
          res.cell_row = 7'd0;
          res.glyph    = 7'd0;
          res.fg_out   = 32'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tcc_pkg::PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  a_second_phase_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tcc_pkg::PH_SECOND |-> !q_empty && q_head.op == tcc_pkg::CMD_DRAW_SCROLL)
    else $error("second phase without a pending draw plus scroll");

  a_pair_keeps_order: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.last |=> out_valid_r && !out_data_r.last && phase_r == tcc_pkg::PH_SECOND)
    else $error("first half of a pair lost its follow-up");

endmodule

### hdl/text_console_cursor_engine.sv
// Text console cursor engine. Takes one item per cycle while in_full is low (a
// character byte or a clear request) and gives draw, scroll and clear commands through
// a queue-style result port. The front end updates the cursor in the cycle an item is
// accepted and pushes at most one command into a four-entry command queue; the back end
// turns each command into result items, one per cycle while the output register can
// load, so a printable byte that wraps past the last row gives two result items. The
// first result of an item passes through the command queue and then the output register.
// Bytes that give no result (carriage return, plain moves, ignored codes) leave the queue
// untouched. in_full rises only when the command queue is full, which happens when
// results are not popped or draw plus scroll pairs come in a long run. Configuration
// goes through an APB-style port at byte addresses 4*i, and must only be written
// while no item is in flight.
module text_console_cursor_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  tcc_pkg::in_item_t           in_data,
  input  logic                        out_pop,
  output logic                        out_empty,
  output tcc_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tcc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  tcc_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  logic [2:0]    reg_idx;

  logic          q_wr;
  logic          q_rd;
  logic          q_full;
  logic          q_empty;
  tcc_pkg::cmd_t q_wdata;
  tcc_pkg::cmd_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns       <= tcc_pkg::RST_COLUMNS;
      cfg_r.rows          <= tcc_pkg::RST_ROWS;
      cfg_r.tab_shift     <= tcc_pkg::RST_TAB_SHIFT;
      cfg_r.fore_color    <= tcc_pkg::RST_FORE;
      cfg_r.back_color    <= tcc_pkg::RST_BACK;
      cfg_r.output_enable <= tcc_pkg::RST_OUT_EN;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tcc_pkg::REG_COLUMNS:   cfg_r.columns       <= cfg_pwdata[7:0];
        tcc_pkg::REG_ROWS:      cfg_r.rows          <= cfg_pwdata[6:0];
        tcc_pkg::REG_TAB_SHIFT: cfg_r.tab_shift     <= cfg_pwdata[2:0];
        tcc_pkg::REG_FORE:      cfg_r.fore_color    <= cfg_pwdata;
        tcc_pkg::REG_BACK:      cfg_r.back_color    <= cfg_pwdata;
        tcc_pkg::REG_OUT_EN:    cfg_r.output_enable <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tcc_pkg::REG_COLUMNS:   cfg_prdata = {24'd0, cfg_r.columns};
      tcc_pkg::REG_ROWS:      cfg_prdata = {25'd0, cfg_r.rows};
      tcc_pkg::REG_TAB_SHIFT: cfg_prdata = {29'd0, cfg_r.tab_shift};
      tcc_pkg::REG_FORE:      cfg_prdata = cfg_r.fore_color;
      tcc_pkg::REG_BACK:      cfg_prdata = cfg_r.back_color;
      tcc_pkg::REG_OUT_EN:    cfg_prdata = {31'd0, cfg_r.output_enable};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  assign in_full = q_full;

  tcc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  tcc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_rd      (q_rd),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  a_disabled_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_r.output_enable |-> !q_wr)
    else $error("command queued while output disabled");

endmodule

### dv/tb_text_console_cursor_engine.sv
`timescale 1ns / 1ps
// self-checking testbench for text_console_cursor_engine: character and clear items in,
// predicted draw, scroll and clear commands compared field by field on the way out
// depends on tcc_pkg and the block itself
module tb_text_console_cursor_engine;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 190;
  localparam int MUTED_ITEMS    = 24;

  typedef enum int {
    POP_ALWAYS,
    POP_COIN,
    POP_PATTERN,
    POP_MOSTLY
  } pop_mode_t;

  typedef struct {
    bit                 is_write;
    logic [2:0]         reg_idx;
    logic [31:0]        reg_val;
    tcc_pkg::in_item_t  item;
    bit                 typed;
    tcc_pkg::out_item_t typed_cmd;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  tcc_pkg::in_item_t  in_data = '0;
  logic               out_pop = 1'b0;
  logic               out_empty;
  tcc_pkg::out_item_t out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [tcc_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  text_console_cursor_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the registers and the cursor
  tcc_pkg::cfg_t      shadow_cfg;
  logic [7:0]         cur_col;
  logic [6:0]         cur_row;
  tcc_pkg::out_item_t expected_cmds[$];
  plan_row_t          plan[$];

  int errors = 0;
  int items_sent = 0;
  int n_draw = 0;
  int n_scroll = 0;
  int n_clear = 0;
  int hold_requests = 0;
  int holds_done = 0;

  function automatic tcc_pkg::out_item_t make_cmd(logic [1:0] kind, logic [7:0] col,
                                                  logic [6:0] row, logic [6:0] glyph,
                                                  logic [31:0] fg);
    tcc_pkg::out_item_t cmd;
    cmd.kind     = kind;
    cmd.cell_col = col;
    cmd.cell_row = row;
    cmd.glyph    = glyph;
    cmd.fg_out   = fg;
    cmd.bg_out   = shadow_cfg.back_color;
    cmd.last     = 1'b0;
    return cmd;
  endfunction

  // moves to the start of the next line, returns 1 when the screen has to scroll
  function automatic bit line_feed();
    int unsigned nrows;
    int unsigned nxt;
    nrows = (shadow_cfg.rows == 7'd0) ? 32'd1 : 32'(shadow_cfg.rows);
    if (nrows > 32'(tcc_pkg::MAX_ROWS)) nrows = 32'(tcc_pkg::MAX_ROWS);
    nxt = 32'(cur_row) + 32'd1;
    cur_col = '0;
    line_feed = 1'b0;
    if (nxt >= nrows) begin
      line_feed = 1'b1;
      nxt = nrows - 32'd1;
    end
    cur_row = nxt[6:0];
  endfunction

  function automatic void track_cursor(tcc_pkg::in_item_t it, bit keep);
    tcc_pkg::out_item_t cmds[$];
    int unsigned ncols;
    int unsigned stop;
    int unsigned col;
    if (!shadow_cfg.output_enable) return;
    ncols = (shadow_cfg.columns == 8'd0) ? 32'd1 : 32'(shadow_cfg.columns);
    if (ncols > 32'(tcc_pkg::MAX_COLUMNS)) ncols = 32'(tcc_pkg::MAX_COLUMNS);
    if (it.action == tcc_pkg::ACT_CLEAR) begin
      cmds.push_back(make_cmd(tcc_pkg::KIND_CLEAR, 8'd0, 7'd0, 7'd0, 32'd0));
      cur_col = '0;
      cur_row = '0;
    end else begin
      case (it.char_code)
        tcc_pkg::CH_LF: begin
          if (line_feed())
            cmds.push_back(make_cmd(tcc_pkg::KIND_SCROLL, 8'd0, 7'd0, 7'd0, 32'd0));
        end
        tcc_pkg::CH_CR: cur_col = '0;
        tcc_pkg::CH_TAB: begin
          stop = 32'd1 << shadow_cfg.tab_shift;
          col  = (32'(cur_col) + stop) & ~(stop - 32'd1);
          if (col >= ncols) begin
            if (line_feed())
              cmds.push_back(make_cmd(tcc_pkg::KIND_SCROLL, 8'd0, 7'd0, 7'd0, 32'd0));
          end else begin
            cur_col = col[7:0];
          end
        end
        tcc_pkg::CH_BS: begin
          if (cur_col != 8'd0) begin
            cur_col = cur_col - 8'd1;
            cmds.push_back(make_cmd(tcc_pkg::KIND_DRAW, cur_col, cur_row,
                                    tcc_pkg::CH_SPACE[6:0], shadow_cfg.fore_color));
          end
        end
        default: begin
          // bytes with the top bit set count as negative and are dropped
          if (it.char_code >= tcc_pkg::CH_SPACE && !it.char_code[7]) begin
            cmds.push_back(make_cmd(tcc_pkg::KIND_DRAW, cur_col, cur_row,
                                    it.char_code[6:0], shadow_cfg.fore_color));
            col = 32'(cur_col) + 32'd1;
            if (col >= ncols) begin
              if (line_feed())
                cmds.push_back(make_cmd(tcc_pkg::KIND_SCROLL, 8'd0, 7'd0, 7'd0, 32'd0));
            end else begin
              cur_col = col[7:0];
            end
          end
        end
      endcase
    end
    if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
    if (keep) foreach (cmds[i]) expected_cmds.push_back(cmds[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // result side: check every popped command, then pick the next pop
  pop_mode_t          rx_mode = POP_ALWAYS;
  logic [15:0]        rx_pattern = '1;
  int unsigned        rx_cycle = 0;
  int                 hold_left = 0;
  bit                 pop_next;
  tcc_pkg::out_item_t want_cmd;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t command with none expected: %h", $time, out_data);
      end else begin
        want_cmd = expected_cmds.pop_front();
        check_field("kind", 32'(want_cmd.kind), 32'(out_data.kind));
        check_field("cell_col", 32'(want_cmd.cell_col), 32'(out_data.cell_col));
        check_field("cell_row", 32'(want_cmd.cell_row), 32'(out_data.cell_row));
        check_field("glyph", 32'(want_cmd.glyph), 32'(out_data.glyph));
        check_field("fg_out", want_cmd.fg_out, out_data.fg_out);
        check_field("bg_out", want_cmd.bg_out, out_data.bg_out);
        check_field("last", 32'(want_cmd.last), 32'(out_data.last));
      end
      case (out_data.kind)
        tcc_pkg::KIND_DRAW:   n_draw++;
        tcc_pkg::KIND_SCROLL: n_scroll++;
        tcc_pkg::KIND_CLEAR:  n_clear++;
        default: ;
      endcase
    end
    if (rx_cycle[7:0] == 8'd0) begin
      rx_mode    = pop_mode_t'($urandom_range(3));
      rx_pattern = 16'($urandom);
    end
    rx_cycle++;
    if (hold_requests != holds_done) begin
      holds_done = hold_requests;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop_next = 1'b0;
    end else begin
      case (rx_mode)
        POP_ALWAYS:  pop_next = 1'b1;
        POP_COIN:    pop_next = 1'($urandom_range(1));
        POP_PATTERN: pop_next = rx_pattern[rx_cycle[3:0]];
        default:     pop_next = ($urandom_range(9) != 0);
      endcase
    end
    out_pop <= pop_next;
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_psel || (in_push && !in_full) || (out_pop && !out_empty))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_text_console_cursor_engine: done, errors");
    $finish;
  end

  task automatic push_item(tcc_pkg::in_item_t it, bit typed, tcc_pkg::out_item_t typed_cmd);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    items_sent++;
    if (typed) begin
      track_cursor(it, 1'b0);
      expected_cmds.push_back(typed_cmd);
    end else begin
      track_cursor(it, 1'b1);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    // items with no command may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // read the register back in a second transfer
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want = '0;
    case (idx)
      tcc_pkg::REG_COLUMNS: begin
        shadow_cfg.columns = val[7:0];
        want = {24'd0, val[7:0]};
      end
      tcc_pkg::REG_ROWS: begin
        shadow_cfg.rows = val[6:0];
        want = {25'd0, val[6:0]};
      end
      tcc_pkg::REG_TAB_SHIFT: begin
        shadow_cfg.tab_shift = val[2:0];
        want = {29'd0, val[2:0]};
      end
      tcc_pkg::REG_FORE: begin
        shadow_cfg.fore_color = val;
        want = val;
      end
      tcc_pkg::REG_BACK: begin
        shadow_cfg.back_color = val;
        want = val;
      end
      tcc_pkg::REG_OUT_EN: begin
        shadow_cfg.output_enable = val[0];
        want = {31'd0, val[0]};
      end
      default: ;
    endcase
    check_field("cfg readback", want, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tcc_pkg::in_item_t rand_item();
    tcc_pkg::in_item_t it;
    int unsigned       pick;
    pick = $urandom_range(99);
    it.action = tcc_pkg::ACT_PUT;
    if (pick < 4) begin
      it.action    = tcc_pkg::ACT_CLEAR;
      it.char_code = 8'($urandom);
    end else if (pick < 50) it.char_code = 8'($urandom_range(127, 32));
    else if (pick < 62)     it.char_code = tcc_pkg::CH_LF;
    else if (pick < 72)     it.char_code = tcc_pkg::CH_TAB;
    else if (pick < 82)     it.char_code = tcc_pkg::CH_BS;
    else if (pick < 87)     it.char_code = tcc_pkg::CH_CR;
    else if (pick < 93)     it.char_code = 8'($urandom_range(31, 0));
    else                    it.char_code = 8'($urandom_range(255, 128));
    return it;
  endfunction

  task automatic drive_bursts(int count, bit pause_mid);
    int sent;
    int burst;
    int i;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(24, 1);
      for (i = 0; i < burst && sent < count; i++) begin
        push_item(rand_item(), 1'b0, '0);
        sent++;
      end
      if (pause_mid && !paused && sent >= count / 2) begin
        // hold the input until every command owed so far has come out
        paused = 1'b1;
        in_push <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0) @(posedge clk);
      end else if ($urandom_range(99) < 45) begin
        in_push <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  endtask

  function automatic void put_row(logic act, logic [7:0] code);
    plan_row_t row;
    row = '{default: '0};
    row.item = {act, code};
    plan.push_back(row);
  endfunction

  function automatic void typed_row(logic act, logic [7:0] code, logic [1:0] kind,
                                    logic [7:0] col, logic [6:0] crow, logic [6:0] glyph,
                                    logic [31:0] fg, logic [31:0] bg);
    plan_row_t row;
    row = '{default: '0};
    row.item               = {act, code};
    row.typed              = 1'b1;
    row.typed_cmd.kind     = kind;
    row.typed_cmd.cell_col = col;
    row.typed_cmd.cell_row = crow;
    row.typed_cmd.glyph    = glyph;
    row.typed_cmd.fg_out   = fg;
    row.typed_cmd.bg_out   = bg;
    row.typed_cmd.last     = 1'b1;
    plan.push_back(row);
  endfunction

  function automatic void reg_row(logic [2:0] idx, logic [31:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    plan.push_back(row);
  endfunction

  initial begin
    int unsigned ph_cols;
    int unsigned ph_rows;
    int unsigned ph_tab;
    logic [31:0] ph_fg;
    logic [31:0] ph_bg;
    bit          ph_en;
    int          directed_items;

    shadow_cfg.columns       = tcc_pkg::RST_COLUMNS;
    shadow_cfg.rows          = tcc_pkg::RST_ROWS;
    shadow_cfg.tab_shift     = tcc_pkg::RST_TAB_SHIFT;
    shadow_cfg.fore_color    = tcc_pkg::RST_FORE;
    shadow_cfg.back_color    = tcc_pkg::RST_BACK;
    shadow_cfg.output_enable = tcc_pkg::RST_OUT_EN;
    cur_col = '0;
    cur_row = '0;

    // reset geometry: 80 x 25, tab stops of 4, white on black
    typed_row(tcc_pkg::ACT_PUT, 8'd65, tcc_pkg::KIND_DRAW, 8'd0, 7'd0, 7'd65,
              32'hFFFF_FFFF, 32'h0);
    typed_row(tcc_pkg::ACT_PUT, 8'd127, tcc_pkg::KIND_DRAW, 8'd1, 7'd0, 7'd127,
              32'hFFFF_FFFF, 32'h0);
    typed_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_SPACE, tcc_pkg::KIND_DRAW, 8'd2, 7'd0, 7'd32,
              32'hFFFF_FFFF, 32'h0);
    typed_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_BS, tcc_pkg::KIND_DRAW, 8'd2, 7'd0, 7'd32,
              32'hFFFF_FFFF, 32'h0);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_TAB);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_CR);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_LF);
    put_row(tcc_pkg::ACT_PUT, 8'd0);
    put_row(tcc_pkg::ACT_PUT, 8'd31);
    put_row(tcc_pkg::ACT_PUT, 8'd128);
    put_row(tcc_pkg::ACT_PUT, 8'd255);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_BS);
    typed_row(tcc_pkg::ACT_CLEAR, 8'd255, tcc_pkg::KIND_CLEAR, 8'd0, 7'd0, 7'd0,
              32'h0, 32'h0);
    // zero geometry acts as a single cell: every step scrolls
    reg_row(tcc_pkg::REG_COLUMNS, 32'd0);
    reg_row(tcc_pkg::REG_ROWS, 32'd0);
    reg_row(tcc_pkg::REG_FORE, 32'h0);
    reg_row(tcc_pkg::REG_BACK, 32'hFFFF_FFFF);
    put_row(tcc_pkg::ACT_PUT, 8'd90);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_LF);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_TAB);
    typed_row(tcc_pkg::ACT_CLEAR, 8'd0, tcc_pkg::KIND_CLEAR, 8'd0, 7'd0, 7'd0,
              32'h0, 32'hFFFF_FFFF);
    // widest screen with tab stops beyond the register's nominal range
    reg_row(tcc_pkg::REG_COLUMNS, 32'd255);
    reg_row(tcc_pkg::REG_ROWS, 32'd127);
    reg_row(tcc_pkg::REG_TAB_SHIFT, 32'd7);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_TAB);
    put_row(tcc_pkg::ACT_PUT, 8'd126);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_TAB);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_TAB);
    // shrink under the cursor, which sits at column 128 of row 1
    reg_row(tcc_pkg::REG_COLUMNS, 32'd10);
    reg_row(tcc_pkg::REG_ROWS, 32'd1);
    reg_row(tcc_pkg::REG_TAB_SHIFT, 32'd0);
    put_row(tcc_pkg::ACT_PUT, 8'd120);
    put_row(tcc_pkg::ACT_PUT, tcc_pkg::CH_TAB);
    // muted output drops even a clear
    reg_row(tcc_pkg::REG_OUT_EN, 32'd0);
    put_row(tcc_pkg::ACT_CLEAR, 8'd0);
    put_row(tcc_pkg::ACT_PUT, 8'd65);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].typed_cmd);
      end
    end
    directed_items = items_sent;

    for (int phase = 0; phase < PHASES; phase++) begin
      ph_fg = $urandom;
      ph_bg = $urandom;
      ph_en = 1'b1;
      ph_tab = $urandom_range(7, 0);
      case (phase)
        0: begin
          ph_cols = 32'(tcc_pkg::RST_COLUMNS);
          ph_rows = 32'(tcc_pkg::RST_ROWS);
          ph_tab  = 32'(tcc_pkg::RST_TAB_SHIFT);
        end
        1, 6: begin
          ph_cols = $urandom_range(12, 1);
          ph_rows = $urandom_range(5, 1);
        end
        2: begin
          ph_cols = 32'(tcc_pkg::MAX_COLUMNS);
          ph_rows = 32'(tcc_pkg::MAX_ROWS);
          ph_tab  = 4;
          ph_fg   = 32'hFFFF_FFFF;
          ph_bg   = 32'h0;
        end
        3: begin
          ph_cols = 0;
          ph_rows = 0;
          ph_fg   = 32'h0;
          ph_bg   = 32'hFFFF_FFFF;
        end
        5: begin
          ph_cols = $urandom_range(255, 0);
          ph_rows = $urandom_range(127, 0);
          ph_en   = 1'b0;
        end
        default: begin
          ph_cols = $urandom_range(255, 0);
          ph_rows = $urandom_range(127, 0);
        end
      endcase
      wait_drained();
      write_reg(tcc_pkg::REG_COLUMNS, ph_cols);
      write_reg(tcc_pkg::REG_ROWS, ph_rows);
      write_reg(tcc_pkg::REG_TAB_SHIFT, ph_tab);
      write_reg(tcc_pkg::REG_FORE, ph_fg);
      write_reg(tcc_pkg::REG_BACK, ph_bg);
      write_reg(tcc_pkg::REG_OUT_EN, {31'd0, ph_en});
      // small screens give draw plus scroll pairs, so a long pop hold fills the queue
      if (phase == 1) hold_requests++;
      drive_bursts(ph_en ? PHASE_ITEMS : MUTED_ITEMS, phase == 4);
    end

    wait_drained();
    $display("covered %0d items (%0d from the directed table) over %0d register settings",
             items_sent, directed_items, PHASES);
    $display("checked %0d draws, %0d scrolls and %0d clears", n_draw, n_scroll, n_clear);
    if (errors == 0) begin
      $display("tb_text_console_cursor_engine: done, clean");
    end else begin
      $display("tb_text_console_cursor_engine: done, errors");
    end
    $finish;
  end

endmodule

### files.f
hdl/tcc_pkg.sv
hdl/tcc_front.sv
hdl/tcc_queue.sv
hdl/tcc_back.sv
hdl/text_console_cursor_engine.sv
dv/tb_text_console_cursor_engine.sv
